FILE: hw/rtl/tfm_pkg.sv
// Shared types, widths, register codes and the reciprocal table for the
// temporal frame mean block. No dependencies.
`default_nettype none

package tfm_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 12;
    localparam int WIN_W       = 5;
    localparam int FRAME_W     = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 17;
    localparam int WIN_MIN     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd1;

    // One running-sum word handed to the rounding divider.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SUM_W-1:0] sum;
    } tfm_sum_word_t;

    // Divider settings, stable while a stream runs.
    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [RECIP_W-1:0] recip;
    } tfm_div_cfg_t;

    // ceil(2^17 / w); floor(sum * recip >> 17) is the exact quotient for
    // every 12-bit sum and every w from 2 to 31.
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [WIN_W-1:0] w);
        logic [RECIP_W-1:0] r;
        begin
            case (w)
                5'd3:    r = 17'd43691;
                5'd4:    r = 17'd32768;
                5'd5:    r = 17'd26215;
                5'd6:    r = 17'd21846;
                5'd7:    r = 17'd18725;
                5'd8:    r = 17'd16384;
                5'd9:    r = 17'd14564;
                5'd10:   r = 17'd13108;
                5'd11:   r = 17'd11916;
                5'd12:   r = 17'd10923;
                5'd13:   r = 17'd10083;
                5'd14:   r = 17'd9363;
                5'd15:   r = 17'd8739;
                5'd16:   r = 17'd8192;
                5'd17:   r = 17'd7711;
                5'd18:   r = 17'd7282;
                5'd19:   r = 17'd6899;
                5'd20:   r = 17'd6554;
                5'd21:   r = 17'd6242;
                5'd22:   r = 17'd5958;
                5'd23:   r = 17'd5699;
                5'd24:   r = 17'd5462;
                5'd25:   r = 17'd5243;
                5'd26:   r = 17'd5042;
                5'd27:   r = 17'd4855;
                5'd28:   r = 17'd4682;
                5'd29:   r = 17'd4520;
                5'd30:   r = 17'd4370;
                5'd31:   r = 17'd4229;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tfm_round_div.sv
// Rounding divider: sum / window, round half to even, with an output register.
// Two stages plus output register; uses tfm_pkg.
`default_nettype none

module tfm_round_div
    import tfm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tfm_sum_word_t sum_word,
    output logic               sum_ready,
    input  wire tfm_div_cfg_t  div_cfg,
    output logic               mean_valid,
    input  wire logic          mean_stall,
    output logic [PIX_W-1:0]   mean_pixel,
    output logic               frame_end
);

    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s3_valid_reg;
    logic             s3_last_reg;
    logic [SUM_W-1:0] s3_sum_reg;
    logic [SUM_W-1:0] s3_q_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] out_mean_reg;

    logic                     out_ready;
    logic                     s3_ready;
    logic                     s2_ready;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]         quot;
    logic [SUM_W+WIN_W-1:0]   qw;
    logic [SUM_W-1:0]         rem;
    logic [WIN_W:0]           rem_x2;
    logic                     round_up;
    logic [PIX_W-1:0]         mean;

    assign out_ready = !out_valid_reg || !mean_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign sum_ready = s2_ready;

    // quotient by reciprocal multiply
    assign prod = {{RECIP_W{1'b0}}, s2_sum_reg} * {{SUM_W{1'b0}}, div_cfg.recip};
    assign quot = prod[RECIP_SHIFT +: SUM_W];

    // remainder is below the window, so its low bits carry it
    assign qw       = {{WIN_W{1'b0}}, s3_q_reg} * {{SUM_W{1'b0}}, div_cfg.window};
    assign rem      = s3_sum_reg - qw[SUM_W-1:0];
    assign rem_x2   = {rem[WIN_W-1:0], 1'b0};
    assign round_up = (rem_x2 > {1'b0, div_cfg.window})
                   || ((rem_x2 == {1'b0, div_cfg.window}) && s3_q_reg[0]);
    assign mean     = s3_q_reg[PIX_W-1:0] + {{(PIX_W-1){1'b0}}, round_up};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= sum_word.valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && sum_word.valid)
        begin
            s2_sum_reg  <= sum_word.sum;
            s2_last_reg <= sum_word.last;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_sum_reg  <= s2_sum_reg;
            s3_q_reg    <= quot;
            s3_last_reg <= s2_last_reg;
        end
        if (out_ready && s3_valid_reg)
        begin
            out_mean_reg <= mean;
            out_last_reg <= s3_last_reg;
        end
    end

    assign mean_valid = out_valid_reg;
    assign mean_pixel = out_mean_reg;
    assign frame_end  = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/temporal_frame_mean_unit.sv
// Temporal frame mean: one pixel per clock unless a stalled output backs up the pipeline; the result
// word passes the s1, s2, s3 and output registers after its pixel is taken; throughput is one word per
// cycle, set by the one read and one write per cycle on the sum memory (adjacent hits to one entry are forwarded).
// Reset clears control, window 2, frame MAX_PIXELS; sum and history memories
// are not cleared, and their contents are only used where the current stream wrote them.
// Depends on tfm_pkg and tfm_round_div.
`default_nettype none

module temporal_frame_mean_unit
    import tfm_pkg::*;
#(
    parameter int MAX_WINDOW = 16,
    parameter int MAX_PIXELS = 65536
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire logic [PIX_W-1:0]      pixel,
    output logic                       mean_valid,
    input  wire logic                  mean_stall,
    output logic [PIX_W-1:0]           mean_pixel,
    output logic                       frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HIST_DEPTH = MAX_WINDOW * MAX_PIXELS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int PIX_AW     = $clog2(MAX_PIXELS);
    localparam int SLOT_W     = $clog2(MAX_WINDOW);

    logic [SUM_W-1:0] sum_mem  [MAX_PIXELS];
    logic [PIX_W-1:0] hist_mem [HIST_DEPTH];

    logic [PIX_AW-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [HIST_AW-1:0] base_reg, base_next;
    logic [WIN_W-1:0]   seen_reg, seen_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;
    logic [PIX_AW-1:0]  last_pos_reg, last_pos_next;

    logic               s1_valid_reg;
    logic [PIX_AW-1:0]  s1_pos_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    logic               s1_first_reg;
    logic               s1_sub_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic               fwd_valid_reg;
    logic [SUM_W-1:0]   fwd_sum_reg;
    logic [SUM_W-1:0]   sum_rd_reg;
    logic [PIX_W-1:0]   hist_rd_reg;

    logic               accept;
    logic               cfg_write;
    logic               s1_ready;
    logic               s1_adv;
    logic               div_ready;
    logic [HIST_AW-1:0] hist_addr;
    logic               cur_last;
    logic               cur_first;
    logic               cur_sub;
    logic               cur_emit;
    logic [SUM_W-1:0]   sum_base;
    logic [SUM_W-1:0]   s1_sum;
    logic [WIN_W-1:0]   win_val;
    logic [31:0]        frame_eff;
    tfm_sum_word_t      sum_word;
    tfm_div_cfg_t       div_cfg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign s1_ready    = !s1_valid_reg || !s1_emit_reg || div_ready;
    assign s1_adv      = s1_valid_reg && s1_ready;
    assign pixel_stall = !s1_ready;
    assign accept      = pixel_valid && !pixel_stall;

    assign hist_addr = base_reg + {{(HIST_AW-PIX_AW){1'b0}}, pos_reg};
    assign cur_last  = (pos_reg == last_pos_reg);
    assign cur_first = (seen_reg == '0);
    assign cur_sub   = (seen_reg >= win_reg);
    assign cur_emit  = (({1'b0, seen_reg} + (WIN_W+1)'(1)) >= {1'b0, win_reg});

    // History slots differ on consecutive pixels, so only the sum needs a
    // forward path.
    assign sum_base = s1_first_reg ? '0 : (fwd_valid_reg ? fwd_sum_reg : sum_rd_reg);
    assign s1_sum   = sum_base - (s1_sub_reg ? {{(SUM_W-PIX_W){1'b0}}, hist_rd_reg} : '0)
                    + {{(SUM_W-PIX_W){1'b0}}, s1_px_reg};

    assign win_val   = cfg_data[WIN_W-1:0];
    assign frame_eff = (cfg_data == '0) ? 32'd1
                     : ((32'(cfg_data) > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS) : 32'(cfg_data));

    always_comb
    begin
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        base_next     = base_reg;
        seen_next     = seen_reg;
        win_next      = win_reg;
        recip_next    = recip_reg;
        last_pos_next = last_pos_reg;
        if (accept)
        begin
            if (cur_last)
            begin
                pos_next = '0;
                if ((32'(slot_reg) + 32'd1) >= 32'(win_reg))
                begin
                    slot_next = '0;
                    base_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                    base_next = base_reg + HIST_AW'(MAX_PIXELS);
                end
                if (seen_reg < win_reg)
                begin
                    seen_next = seen_reg + WIN_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + PIX_AW'(1);
            end
        end
        if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:
                begin
                    if (win_val < WIN_W'(WIN_MIN))
                    begin
                        win_next = WIN_W'(WIN_MIN);
                    end
                    else if (32'(win_val) > 32'(MAX_WINDOW))
                    begin
                        win_next = WIN_W'(MAX_WINDOW);
                    end
                    else
                    begin
                        win_next = win_val;
                    end
                    recip_next = recip_lookup(win_next);
                    // restart the stream
                    pos_next  = '0;
                    slot_next = '0;
                    base_next = '0;
                    seen_next = '0;
                end
                REG_FRAME_PIXELS:
                begin
                    last_pos_next = PIX_AW'(frame_eff - 32'd1);
                    pos_next      = '0;
                    slot_next     = '0;
                    base_next     = '0;
                    seen_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            slot_reg      <= '0;
            base_reg      <= '0;
            seen_reg      <= '0;
            win_reg       <= WIN_W'(WIN_MIN);
            recip_reg     <= recip_lookup(WIN_W'(WIN_MIN));
            last_pos_reg  <= PIX_AW'(MAX_PIXELS - 1);
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            slot_reg     <= slot_next;
            base_reg     <= base_next;
            seen_reg     <= seen_next;
            win_reg      <= win_next;
            recip_reg    <= recip_next;
            last_pos_reg <= last_pos_next;
            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                // same entry written back on this edge: take the fresh sum
                fwd_valid_reg <= s1_adv && (s1_pos_reg == pos_reg);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos_reg;
            s1_px_reg    <= pixel;
            s1_first_reg <= cur_first;
            s1_sub_reg   <= cur_sub;
            s1_emit_reg  <= cur_emit;
            s1_last_reg  <= cur_last;
            fwd_sum_reg  <= s1_sum;
        end
    end

    // Sum memory: read on accept, write back when stage one advances.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_rd_reg <= sum_mem[pos_reg];
        end
        if (s1_adv)
        begin
            sum_mem[s1_pos_reg] <= s1_sum;
        end
    end

    // History memory: read the oldest frame and replace it in the same access.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_rd_reg         <= hist_mem[hist_addr];
            hist_mem[hist_addr] <= pixel;
        end
    end

    assign sum_word.valid = s1_valid_reg && s1_emit_reg;
    assign sum_word.last  = s1_last_reg;
    assign sum_word.sum   = s1_sum;
    assign div_cfg.window = win_reg;
    assign div_cfg.recip  = recip_reg;

    tfm_round_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_word   (sum_word),
        .sum_ready  (div_ready),
        .div_cfg    (div_cfg),
        .mean_valid (mean_valid),
        .mean_stall (mean_stall),
        .mean_pixel (mean_pixel),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/tfm_checker.sv
// Port-level checks for temporal_frame_mean_unit, attached by bind.
// Depends on tfm_pkg widths only.
`default_nettype none

module tfm_checker
    import tfm_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pixel_valid,
    input wire logic             pixel_stall,
    input wire logic             mean_valid,
    input wire logic             mean_stall,
    input wire logic [PIX_W-1:0] mean_pixel,
    input wire logic             frame_end
);

    // input back-pressure only comes from a full, stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (mean_valid && mean_stall))
        else $error("pixel stall without a blocked output word");

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !mean_valid)
        else $error("output word present right after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mean_valid && mean_stall) |=>
            (mean_valid && $stable(mean_pixel) && $stable(frame_end)))
        else $error("stalled output word changed");

    // a stalled pixel is followed by pixel_valid still high, an unstalled output or an output word
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> pixel_valid || !mean_stall || mean_valid)
        else $error("pipeline state lost under stall");

endmodule

bind temporal_frame_mean_unit tfm_checker u_tfm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .mean_valid  (mean_valid),
    .mean_stall  (mean_stall),
    .mean_pixel  (mean_pixel),
    .frame_end   (frame_end)
);

`default_nettype wire

FILE: bench/tb_temporal_frame_mean_unit.sv
// Self-checking bench for temporal_frame_mean_unit: directed table, then random frame
// streams under three idle mixes, checked word by word against a built-in mean predictor.
// Depends on tfm_pkg and the RTL of temporal_frame_mean_unit.
`default_nettype none

module tb_temporal_frame_mean_unit;
    import tfm_pkg::*;

    localparam int MAX_WINDOW      = 16;
    localparam int MAX_PIXELS      = 65536;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PER_MIX  = 284;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SRC_IDLE_PCT [3] = '{32, 61, 0};
    localparam int DST_IDLE_PCT [3] = '{61, 32, 0};

    // Index field is a don't-care on pixel rows.
    localparam logic [CFG_IDX_W-1:0] REG_NONE    = REG_WINDOW_SIZE;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_TYPED} row_check_e;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             last;
    } mean_word_t;

    // Pixel rows carry the pixel in the low bits of value.
    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        row_check_e            check;
        logic [PIX_W-1:0]      mean;
        logic                  last;
    } stim_row_t;

    localparam int NUM_DIRECTED = 28;
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // reset setup: window 2 over 65536-pixel frames, still warming up
        '{ROW_PIXEL,  REG_NONE,         17'd255,     EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd0,       EXP_NONE,  8'd0,   1'b0},
        // both registers clamped from below: window 2, one-pixel frames
        '{ROW_CONFIG, REG_WINDOW_SIZE,  17'd0,       EXP_NONE,  8'd0,   1'b0},
        '{ROW_CONFIG, REG_FRAME_PIXELS, 17'd0,       EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd255,     EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd255,     EXP_TYPED, 8'd255, 1'b1},
        // ties: 127.5 goes up to 128, 0.5 down to 0, 1.5 up to 2
        '{ROW_PIXEL,  REG_NONE,         17'd0,       EXP_TYPED, 8'd128, 1'b1},
        '{ROW_PIXEL,  REG_NONE,         17'd1,       EXP_TYPED, 8'd0,   1'b1},
        '{ROW_PIXEL,  REG_NONE,         17'd2,       EXP_TYPED, 8'd2,   1'b1},
        // both registers clamped from above
        '{ROW_CONFIG, REG_WINDOW_SIZE,  17'h1FFFF,   EXP_NONE,  8'd0,   1'b0},
        '{ROW_CONFIG, REG_FRAME_PIXELS, 17'h1FFFF,   EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'h0005A,   EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'h000A5,   EXP_NONE,  8'd0,   1'b0},
        // upper data bits drop on a window write: window 3
        '{ROW_CONFIG, REG_WINDOW_SIZE,  17'h10003,   EXP_NONE,  8'd0,   1'b0},
        '{ROW_CONFIG, REG_FRAME_PIXELS, 17'd3,       EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd10,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd20,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd30,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd40,      EXP_PRED,  8'd0,   1'b0},
        // write past the register list mid-frame: stream must carry on
        '{ROW_CONFIG, REG_SPARE_A,      17'd7,       EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd50,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd60,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd70,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd80,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_CONFIG, REG_SPARE_B,      17'h1FFFF,   EXP_NONE,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd90,      EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd255,     EXP_PRED,  8'd0,   1'b0},
        '{ROW_PIXEL,  REG_NONE,         17'd0,       EXP_PRED,  8'd0,   1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel;
    logic                  mean_valid;
    logic                  mean_stall;
    logic [PIX_W-1:0]      mean_pixel;
    logic                  frame_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [PIX_W-1:0] hist_mem [int];
    logic [SUM_W-1:0] sum_mem [int];
    int unsigned      window_len;
    int unsigned      frame_len;
    int unsigned      pixel_pos;
    int unsigned      hist_slot;
    int unsigned      frames_done;

    mean_word_t mean_words_due [$];
    int         error_count;
    int         src_idle_pct;
    int         dst_idle_pct;
    bit         hold_request;
    int         cycle_count;

    temporal_frame_mean_unit #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .mean_valid  (mean_valid),
        .mean_stall  (mean_stall),
        .mean_pixel  (mean_pixel),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the per-position running sums by one pixel; return 1 when a word is due.
    function automatic bit step_frame_mean(input logic [PIX_W-1:0] px,
                                           output mean_word_t word);
        int unsigned p;
        int unsigned slot;
        int unsigned hidx;
        int unsigned total;
        int unsigned q;
        int unsigned r;
        bit          hit;
        p    = pixel_pos;
        slot = hist_slot;
        if (p >= frame_len)
            p = 0;
        if (slot >= window_len)
            slot = 0;
        hidx  = slot * MAX_PIXELS + p;
        total = (frames_done == 0) ? 0 : sum_mem[p];
        if (frames_done >= window_len)
            total = total - hist_mem[hidx];
        total = (total + px) & 32'hFFF;
        sum_mem[p]     = total[SUM_W-1:0];
        hist_mem[hidx] = px;
        // round half to even
        q = total / window_len;
        r = total % window_len;
        if (2 * r > window_len || (2 * r == window_len && q[0]))
            q++;
        word.mean = q[PIX_W-1:0];
        word.last = (p + 1 >= frame_len);
        hit = (frames_done + 1 >= window_len);
        if (word.last)
        begin
            pixel_pos = 0;
            slot++;
            hist_slot = (slot >= window_len) ? 0 : slot;
            if (frames_done < window_len)
                frames_done++;
        end
        else
        begin
            pixel_pos = p + 1;
            hist_slot = slot;
        end
        return hit;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px, input row_check_e check,
                              input mean_word_t typed);
        mean_word_t word;
        bit         hit;
        while ($urandom_range(99) < src_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do
            @(posedge clk);
        while (pixel_stall);
        hit = step_frame_mean(px, word);
        if (check == EXP_TYPED)
            mean_words_due = {mean_words_due, typed};
        else if (check == EXP_PRED && hit)
            mean_words_due = {mean_words_due, word};
    endtask

    // Write only once the pipeline has drained.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        int unsigned v;
        pixel_valid <= 1'b0;
        while (mean_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_WINDOW_SIZE)
        begin
            v = value[WIN_W-1:0];
            if (v < WIN_MIN)
                v = WIN_MIN;
            if (v > MAX_WINDOW)
                v = MAX_WINDOW;
            window_len = v;
        end
        else if (index == REG_FRAME_PIXELS)
        begin
            v = value;
            if (v < 1)
                v = 1;
            if (v > MAX_PIXELS)
                v = MAX_PIXELS;
            frame_len = v;
        end
        if (index == REG_WINDOW_SIZE || index == REG_FRAME_PIXELS)
        begin
            pixel_pos   = 0;
            hist_slot   = 0;
            frames_done = 0;
        end
    endtask

    // receiver: random stall, or a long hold when requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        mean_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                mean_stall <= 1'b1;
                hold_left--;
            end
            else
                mean_stall <= ($urandom_range(99) < dst_idle_pct);
        end
    end

    // result checker
    initial
    begin
        mean_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && mean_valid && !mean_stall)
            begin
                if (mean_words_due.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, got mean %0d end %0b",
                             $time, mean_pixel, frame_end);
                    error_count++;
                end
                else
                begin
                    want = mean_words_due.pop_front();
                    if (mean_pixel !== want.mean)
                    begin
                        $display("%0t mean_pixel mismatch: expected %0d, got %0d",
                                 $time, want.mean, mean_pixel);
                        error_count++;
                    end
                    if (frame_end !== want.last)
                    begin
                        $display("%0t frame_end mismatch: expected %0b, got %0b",
                                 $time, want.last, frame_end);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int               mix;
        int               phase;
        int               sent;
        int               win;
        int               fpix;
        int               count;
        logic [PIX_W-1:0] px;
        error_count  = 0;
        hold_request = 1'b0;
        window_len   = WIN_MIN;
        frame_len    = MAX_PIXELS;
        pixel_pos    = 0;
        hist_slot    = 0;
        frames_done  = 0;
        src_idle_pct = SRC_IDLE_PCT[0];
        dst_idle_pct = DST_IDLE_PCT[0];
        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_WINDOW_SIZE;
        cfg_data    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CONFIG)
                write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value);
            else
                send_pixel(DIRECTED_ROWS[i].value[PIX_W-1:0], DIRECTED_ROWS[i].check,
                           '{mean: DIRECTED_ROWS[i].mean, last: DIRECTED_ROWS[i].last});
        end

        for (mix = 0; mix < 3; mix++)
        begin
            src_idle_pct = SRC_IDLE_PCT[mix];
            dst_idle_pct = DST_IDLE_PCT[mix];
            sent  = 0;
            phase = 0;
            while (sent < RANDOM_PER_MIX)
            begin
                // open each mix at the window extremes
                if (phase == 0)
                    win = MAX_WINDOW;
                else if (phase == 1)
                    win = WIN_MIN;
                else if ($urandom_range(3) == 0)
                    win = $urandom_range(WIN_MIN, MAX_WINDOW);
                else
                    win = $urandom_range(WIN_MIN, 6);
                if (win > 8)
                    fpix = $urandom_range(1, 4);
                else if ($urandom_range(5) == 0)
                    fpix = $urandom_range(9, 48);
                else
                    fpix = $urandom_range(1, 8);
                if ($urandom_range(1))
                begin
                    write_register(REG_WINDOW_SIZE, {12'($urandom), 5'(win)});
                    write_register(REG_FRAME_PIXELS, 17'(fpix));
                end
                else
                begin
                    write_register(REG_FRAME_PIXELS, 17'(fpix));
                    write_register(REG_WINDOW_SIZE, {12'($urandom), 5'(win)});
                end
                // back-pressure the output long enough to fill the block
                if (mix == 2 && phase == 1)
                    hold_request = 1'b1;
                count = (win + $urandom_range(1, 4)) * fpix + $urandom_range(0, fpix - 1);
                if (count > RANDOM_PER_MIX - sent)
                    count = RANDOM_PER_MIX - sent;
                repeat (count)
                begin
                    case ($urandom_range(7))
                        0:       px = '0;
                        1:       px = '1;
                        default: px = PIX_W'($urandom_range(255));
                    endcase
                    send_pixel(px, EXP_PRED, '0);
                end
                sent  += count;
                phase++;
            end
        end

        pixel_valid <= 1'b0;
        while (mean_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/tfm_pkg.sv
hw/rtl/tfm_round_div.sv
hw/rtl/temporal_frame_mean_unit.sv
hw/rtl/tfm_checker.sv
bench/tb_temporal_frame_mean_unit.sv
